>>> rtl/core/ft12_rx_pkg.sv
// ----------------------------------------------------------------------------
// FT1.2 link frame receiver - shared package
// Types and constants for the byte pipeline, frame checker and result register.
// ----------------------------------------------------------------------------
package ft12_rx_pkg;

   // Frame delimiters and application bytes looked for
   localparam logic [7:0] START_FIXED = 8'h10;
   localparam logic [7:0] START_VAR   = 8'h68;
   localparam logic [7:0] END_BYTE    = 8'h16;
   localparam logic [7:0] TYPE_GI     = 8'h64;
   localparam logic [7:0] CAUSE_GI    = 8'h14;
   localparam logic [7:0] TYPE_CLOCK  = 8'h67;

   // Function codes that map to an action
   localparam logic [3:0] FC_RESET_LINK  = 4'd0;
   localparam logic [3:0] FC_USER_DATA   = 4'd3;
   localparam logic [3:0] FC_LINK_STATUS = 4'd9;

   // Link address reset value
   localparam logic [15:0] STATION_ADDRESS_RESET = 16'd33;

   // Byte positions within a frame
   localparam logic [8:0] POS_FIRST   = 9'd1;
   localparam logic [8:0] POS_SECOND  = 9'd2;
   localparam logic [8:0] POS_THIRD   = 9'd3;
   localparam logic [8:0] POS_FOURTH  = 9'd4;
   localparam logic [8:0] POS_ADDR_LO = 9'd5;
   localparam logic [8:0] POS_ADDR_HI = 9'd6;
   localparam logic [8:0] POS_TYPE    = 9'd7;
   localparam logic [8:0] POS_CAUSE_A = 9'd14;
   localparam logic [8:0] POS_CAUSE_B = 9'd15;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_START   = 3'd1,
      ST_LENGTH      = 3'd2,
      ST_BAD_START2  = 3'd3,
      ST_CHECKSUM    = 3'd4,
      ST_END_BYTE    = 3'd5,
      ST_ADDRESS     = 3'd6,
      ST_DIR_PRM     = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_RESET_LINK = 3'd1,
      ACT_LINK_STAT  = 3'd2,
      ACT_GEN_INTERR = 3'd3,
      ACT_CLOCK_SYNC = 3'd4
   } action_type;

   // One received byte with its start flag
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
      logic       frame_start;
   } in_item_type;

   // One status result
   typedef struct packed {
      status_type status;
      logic       variable_frame;
      logic [3:0] function_code;
      logic       frame_count_bit;
      logic       frame_count_valid;
      action_type action;
   } result_type;

endpackage

>>> rtl/core/ft12_rx_in_reg.sv
// ----------------------------------------------------------------------------
// FT1.2 link frame receiver - input register
// Holds one received byte until the checker can take it.
// ----------------------------------------------------------------------------
module ft12_rx_in_reg
   import ft12_rx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   input  logic        advance,
   output in_item_type item
);

   in_item_type item_ff;
   in_item_type item_in;

   // Stall only while a held item cannot move on this cycle
   assign req_stall = item_ff.valid && !advance;

   always_comb begin
      item_in = item_ff;
      if (!req_stall) begin
         item_in.valid       = req_valid;
         item_in.rx_byte     = req_rx_byte;
         item_in.frame_start = req_frame_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.rx_byte     <= item_in.rx_byte;
      item_ff.frame_start <= item_in.frame_start;
   end

   assign item = item_ff;

endmodule

>>> rtl/core/ft12_rx_check.sv
// ----------------------------------------------------------------------------
// FT1.2 link frame receiver - frame checker
// Tracks the frame position, checksum and captured fields; decides the status.
// ----------------------------------------------------------------------------
module ft12_rx_check
   import ft12_rx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  in_item_type item,
   input  logic        advance,
   input  logic [15:0] station_address,
   output logic        res_valid,
   output result_type  res
);

   logic [8:0]  byte_position_ff,    byte_position_in;
   logic        frame_active_ff,     frame_active_in;
   logic        is_variable_ff,      is_variable_in;
   logic [7:0]  user_length_ff,      user_length_in;
   logic [7:0]  running_sum_ff,      running_sum_in;
   logic [7:0]  control_byte_ff,     control_byte_in;
   logic [15:0] received_address_ff, received_address_in;
   logic [7:0]  type_byte_ff,        type_byte_in;
   logic        cause_seen_ff,       cause_seen_in;

   logic        fire;
   logic [7:0]  b;
   logic [8:0]  p;
   logic [8:0]  sum_pos;
   logic [7:0]  sum_add;
   logic        emit;
   logic        with_ctrl;
   status_type  sts;
   action_type  act;
   logic [3:0]  fc;

   assign fire    = item.valid && advance;
   assign b       = item.rx_byte;
   assign p       = byte_position_ff;
   assign sum_pos = {1'b0, user_length_ff} + POS_FOURTH;
   assign sum_add = running_sum_ff + b;
   assign fc      = control_byte_ff[3:0];

   // Next state and result decision for one byte
   always_comb begin
      byte_position_in    = byte_position_ff;
      frame_active_in     = frame_active_ff;
      is_variable_in      = is_variable_ff;
      user_length_in      = user_length_ff;
      running_sum_in      = running_sum_ff;
      control_byte_in     = control_byte_ff;
      received_address_in = received_address_ff;
      type_byte_in        = type_byte_ff;
      cause_seen_in       = cause_seen_ff;
      emit      = 1'b0;
      with_ctrl = 1'b0;
      sts       = ST_OK;
      act       = ACT_NONE;

      if (fire && item.frame_start) begin
         // New frame: drop anything partial
         byte_position_in    = '0;
         is_variable_in      = 1'b0;
         user_length_in      = '0;
         running_sum_in      = '0;
         control_byte_in     = '0;
         received_address_in = '0;
         type_byte_in        = '0;
         cause_seen_in       = 1'b0;
         frame_active_in     = 1'b1;
         if (b == START_FIXED) begin
            byte_position_in = POS_FIRST;
         end else if (b == START_VAR) begin
            is_variable_in   = 1'b1;
            byte_position_in = POS_FIRST;
         end else begin
            emit = 1'b1;
            sts  = ST_BAD_START;
         end
      end else if (fire && frame_active_ff) begin
         byte_position_in = p + 9'd1;
         if (!is_variable_ff) begin
            // Fixed frame: C Alo Ahi CS end
            if (p == POS_FIRST)  control_byte_in = b;
            if (p == POS_SECOND) received_address_in[7:0]  = b;
            if (p == POS_THIRD)  received_address_in[15:8] = b;
            if (p <= POS_THIRD) begin
               running_sum_in = sum_add;
            end else if (p == POS_FOURTH) begin
               if (b != running_sum_ff) begin
                  emit = 1'b1;
                  sts  = ST_CHECKSUM;
               end
            end else begin
               emit = 1'b1;
            end
         end else begin
            // Variable frame: L L start user bytes CS end
            if (p == POS_FIRST) begin
               user_length_in = b;
            end else if (p == POS_SECOND) begin
               if (b != user_length_ff) begin
                  emit = 1'b1;
                  sts  = ST_LENGTH;
               end
            end else if (p == POS_THIRD) begin
               if (b != START_VAR) begin
                  emit = 1'b1;
                  sts  = ST_BAD_START2;
               end
            end else if (p < sum_pos) begin
               running_sum_in = sum_add;
               if (p == POS_FOURTH) begin
                  control_byte_in = b;
               end else if (p == POS_ADDR_LO) begin
                  received_address_in[7:0] = b;
               end else if (p == POS_ADDR_HI) begin
                  received_address_in[15:8] = b;
               end else if (p == POS_TYPE) begin
                  type_byte_in = b;
               end else if ((p == POS_CAUSE_A || p == POS_CAUSE_B) && b == CAUSE_GI) begin
                  cause_seen_in = 1'b1;
               end
            end else if (p == sum_pos) begin
               if (b != running_sum_ff) begin
                  emit = 1'b1;
                  sts  = ST_CHECKSUM;
               end
            end else begin
               emit = 1'b1;
            end
         end

         // Final checks at the end byte, only where no error is already set
         if (emit && sts == ST_OK) begin
            if (b != END_BYTE) begin
               sts = ST_END_BYTE;
            end else if (received_address_ff != station_address) begin
               sts       = ST_ADDRESS;
               with_ctrl = 1'b1;
            end else if (control_byte_ff[7] || !control_byte_ff[6]) begin
               sts       = ST_DIR_PRM;
               with_ctrl = 1'b1;
            end else begin
               with_ctrl = 1'b1;
               if (fc == FC_RESET_LINK) begin
                  act = ACT_RESET_LINK;
               end else if (fc == FC_LINK_STATUS) begin
                  act = ACT_LINK_STAT;
               end else if (fc == FC_USER_DATA && is_variable_ff) begin
                  if (type_byte_ff == TYPE_GI && cause_seen_ff) begin
                     act = ACT_GEN_INTERR;
                  end else if (type_byte_ff == TYPE_CLOCK) begin
                     act = ACT_CLOCK_SYNC;
                  end
               end
            end
         end
      end

      // Any result closes the frame
      if (emit) frame_active_in = 1'b0;
   end

   // Result fields
   always_comb begin
      res.status            = sts;
      res.variable_frame    = (sts == ST_BAD_START) ? 1'b0 : is_variable_ff;
      res.function_code     = with_ctrl ? control_byte_ff[3:0] : 4'd0;
      res.frame_count_bit   = with_ctrl && control_byte_ff[5];
      res.frame_count_valid = with_ctrl && control_byte_ff[4];
      res.action            = act;
   end

   assign res_valid = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff    <= '0;
         frame_active_ff     <= 1'b0;
         is_variable_ff      <= 1'b0;
         user_length_ff      <= '0;
         running_sum_ff      <= '0;
         control_byte_ff     <= '0;
         received_address_ff <= '0;
         type_byte_ff        <= '0;
         cause_seen_ff       <= 1'b0;
      end else begin
         byte_position_ff    <= byte_position_in;
         frame_active_ff     <= frame_active_in;
         is_variable_ff      <= is_variable_in;
         user_length_ff      <= user_length_in;
         running_sum_ff      <= running_sum_in;
         control_byte_ff     <= control_byte_in;
         received_address_ff <= received_address_in;
         type_byte_ff        <= type_byte_in;
         cause_seen_ff       <= cause_seen_in;
      end
   end

endmodule

>>> rtl/core/ft12_rx_out_reg.sv
// ----------------------------------------------------------------------------
// FT1.2 link frame receiver - result register
// Holds one status item for the result channel and paces the pipeline.
// ----------------------------------------------------------------------------
module ft12_rx_out_reg
   import ft12_rx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   input  result_type res,
   input  logic       rsp_stall,
   output logic       advance,
   output logic       rsp_valid,
   output result_type rsp
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   // Pipeline moves when the result slot is free or being emptied
   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (advance) valid_in = res_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance && res_valid) res_ff <= res;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

endmodule

>>> rtl/core/ft12_link_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// FT1.2 link frame receiver core
// Checks fixed and variable FT1.2 link frames byte by byte and reports one
// status item per frame with the control bits and the requested action.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------
//   req_     | in        | req_valid/req_stall | rx_byte, frame_start
//   rsp_     | out       | rsp_valid/rsp_stall | status, variable_frame,
//            |           |                     | function_code, fcb, fcv, action
//   csr_     | in        | csr_write_enable    | station_address (16 bit)
//
// One byte per cycle is accepted while req_stall is low; a byte's result is
// offered on rsp_ after the input register and then the result register.
// The checksum add and position compare sit between those two registers.
// Reset is synchronous and clears the frame state; station address returns to 33.
// A stalled result holds the pipeline; one further byte waits in the input
// register before req_stall rises.
// ----------------------------------------------------------------------------
module ft12_link_frame_receiver_core
   import ft12_rx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_variable_frame,
   output logic [3:0]  rsp_function_code,
   output logic        rsp_frame_count_bit,
   output logic        rsp_frame_count_valid,
   output logic [2:0]  rsp_action,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic [15:0] station_address_ff;
   in_item_type item;
   logic        advance;
   logic        res_valid;
   result_type  res;
   result_type  rsp;

   // Link address register
   always_ff @(posedge clock) begin
      if (reset) begin
         station_address_ff <= STATION_ADDRESS_RESET;
      end else if (csr_write_enable) begin
         station_address_ff <= csr_write_data;
      end
   end

   ft12_rx_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .advance         (advance),
      .item            (item)
   );

   ft12_rx_check u_check (
      .clock           (clock),
      .reset           (reset),
      .item            (item),
      .advance         (advance),
      .station_address (station_address_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   ft12_rx_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_status            = rsp.status;
   assign rsp_variable_frame    = rsp.variable_frame;
   assign rsp_function_code     = rsp.function_code;
   assign rsp_frame_count_bit   = rsp.frame_count_bit;
   assign rsp_frame_count_valid = rsp.frame_count_valid;
   assign rsp_action            = rsp.action;

   // Input side only stalls while an item is held there
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item.valid)
      else $error("input stalled with no item held");

   // Framing errors carry no control bits and no action
   a_error_no_ctrl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK && rsp_status != ST_ADDRESS
       && rsp_status != ST_DIR_PRM)
      |-> (rsp_function_code == 4'd0 && rsp_action == ACT_NONE
           && !rsp_frame_count_bit && !rsp_frame_count_valid))
      else $error("framing error result carries control bits");

   // An action is only requested by a frame that passed every check
   a_action_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action != ACT_NONE) |-> rsp_status == ST_OK)
      else $error("action on a failed frame");

   // Bad start never reports a variable frame
   a_bad_start_fixed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BAD_START) |-> !rsp_variable_frame)
      else $error("bad start flagged as variable frame");

endmodule
